// ===== rtl/prfd_pkg.sv =====
// Shared types, constants and helper functions for the run-length frame decoder.
package prfd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_FRAMES = 4096;

    localparam int W_DIM    = 11;
    localparam int W_COUNT  = 13;
    localparam int W_FRAME  = 12;
    localparam int W_OFFSET = 20;
    localparam int W_LEN    = 18;
    localparam int W_COLOR  = 8;
    localparam int W_AREA   = 21;
    localparam int W_CFGIDX = 2;

    localparam int WIDTH_RESET  = 32;
    localparam int HEIGHT_RESET = 40;
    localparam int COUNT_RESET  = 1;

    localparam logic [W_COLOR-1:0] CODE_SKIP = 8'd254;
    localparam logic [W_COLOR-1:0] CODE_END  = 8'd255;

    localparam logic [W_CFGIDX-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [W_CFGIDX-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [W_CFGIDX-1:0] CFG_COUNT  = 2'd2;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = 2;
    localparam int CMD_CNT_W = 3;
    localparam int RES_DEPTH = 2;
    localparam int RES_PTR_W = 1;
    localparam int RES_CNT_W = 2;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_SKIP
    } phase_t;

    typedef struct packed {
        logic               is_end;
        logic [W_FRAME-1:0] frame;
        logic [W_LEN-1:0]   len;
        logic [W_COLOR-1:0] color;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_push_t;

    typedef struct packed {
        logic [W_FRAME-1:0]  frame_index;
        logic [W_OFFSET-1:0] start_offset;
        logic [W_LEN-1:0]    run_length;
        logic [W_COLOR-1:0]  color;
        logic                frame_end;
        logic                clipped;
    } res_t;

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [W_DIM-1:0] clamp_dim(input logic [W_DIM-1:0] v,
                                                   input logic [W_DIM-1:0] vmax);
        logic [W_DIM-1:0] r;
        r = v;
        if (r == '0)
            r = W_DIM'(1);
        if (r > vmax)
            r = vmax;
        return r;
    endfunction

    function automatic logic [W_COUNT-1:0] clamp_count(input logic [W_COUNT-1:0] v);
        logic [W_COUNT-1:0] r;
        r = v;
        if (r > W_COUNT'(MAX_FRAMES))
            r = W_COUNT'(MAX_FRAMES);
        return r;
    endfunction

endpackage

// ===== rtl/prfd_front.sv =====
// Byte classifier: tracks frame phase and frame number, emits run/end commands.
module prfd_front import prfd_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [W_COLOR-1:0] data_byte,
    input  logic [W_DIM-1:0]   eff_width,
    input  logic [W_COUNT-1:0] eff_count,
    output cmd_push_t          cmd_push
);

    phase_t             phase_reg, phase_next;
    logic [W_COUNT-1:0] fnum_reg, fnum_next;
    logic [W_LEN-1:0]   hdr_prod;

    // blank rows times width, at most 255 * 1024
    assign hdr_prod = W_LEN'(data_byte) * W_LEN'(eff_width);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            fnum_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            fnum_reg  <= fnum_next;
        end
    end

    always_comb
    begin
        phase_next            = phase_reg;
        fnum_next             = fnum_reg;
        cmd_push.valid        = 1'b0;
        cmd_push.cmd.is_end   = 1'b0;
        cmd_push.cmd.frame    = fnum_reg[W_FRAME-1:0];
        cmd_push.cmd.len      = '0;
        cmd_push.cmd.color    = '0;
        if (accept && (fnum_reg < eff_count))
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    cmd_push.valid   = 1'b1;
                    cmd_push.cmd.len = hdr_prod;
                    phase_next       = PH_BODY;
                end
                PH_SKIP:
                begin
                    cmd_push.valid   = 1'b1;
                    cmd_push.cmd.len = W_LEN'(data_byte);
                    phase_next       = PH_BODY;
                end
                PH_BODY:
                begin
                    if (data_byte == CODE_SKIP)
                        phase_next = PH_SKIP;
                    else if (data_byte == CODE_END)
                    begin
                        cmd_push.valid      = 1'b1;
                        cmd_push.cmd.is_end = 1'b1;
                        fnum_next           = fnum_reg + W_COUNT'(1);
                        phase_next          = PH_HEADER;
                    end
                    else
                    begin
                        cmd_push.valid     = 1'b1;
                        cmd_push.cmd.len   = W_LEN'(1);
                        cmd_push.cmd.color = data_byte;
                    end
                end
                default:
                    phase_next = PH_HEADER;
            endcase
        end
    end

endmodule

// ===== rtl/prfd_cmd_queue.sv =====
// Short command queue between the classifier and the run executor.
module prfd_cmd_queue import prfd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_push_t cmd_push,
    input  logic      pop,
    output logic      full,
    output logic      empty,
    output cmd_t      head
);

    cmd_t                 mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CMD_CNT_W-1:0] cnt_reg;
    logic                 do_push, do_pop;

    assign full    = (cnt_reg == CMD_CNT_W'(CMD_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = cmd_push.valid && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= cmd_push.cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + CMD_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + CMD_PTR_W'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + CMD_CNT_W'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - CMD_CNT_W'(1);
        end
    end

endmodule

// ===== rtl/prfd_back.sv =====
// Run executor: raster offset, clipping against the frame area, result queue.
module prfd_back import prfd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_empty,
    input  cmd_t              cmd,
    input  logic [W_AREA-1:0] area,
    input  logic              pop,
    output logic              cmd_pop,
    output logic              res_empty,
    output res_t              res_head
);

    logic [W_AREA-1:0]    offset_reg, offset_next;
    logic [W_AREA-1:0]    off, avail, n, len_ext;
    logic [W_OFFSET-1:0]  start;
    logic                 clip;
    res_t                 res_new;
    logic                 res_push, res_pop;
    res_t                 rmem [RES_DEPTH];
    logic [RES_PTR_W-1:0] rwr_ptr_reg, rrd_ptr_reg;
    logic [RES_CNT_W-1:0] rcnt_reg;

    assign cmd_pop = !cmd_empty && (rcnt_reg < RES_CNT_W'(RES_DEPTH));

    always_comb
    begin
        off     = (offset_reg > area) ? area : offset_reg;
        avail   = area - off;
        len_ext = W_AREA'(cmd.len);
        clip    = (len_ext > avail);
        n       = clip ? avail : len_ext;
        // fully clipped run reports the last pixel of the area
        start   = (off < area) ? W_OFFSET'(off) : W_OFFSET'(area - W_AREA'(1));

        offset_next = offset_reg;
        if (cmd_pop)
        begin
            if (cmd.is_end)
                offset_next = '0;
            else
                offset_next = off + n;
        end

        res_new.frame_index = cmd.frame;
        if (cmd.is_end)
        begin
            res_new.start_offset = '0;
            res_new.run_length   = '0;
            res_new.color        = '0;
            res_new.frame_end    = 1'b1;
            res_new.clipped      = 1'b0;
        end
        else
        begin
            res_new.start_offset = start;
            res_new.run_length   = n[W_LEN-1:0];
            res_new.color        = cmd.color;
            res_new.frame_end    = 1'b0;
            res_new.clipped      = clip;
        end
    end

    // empty runs only clamp the offset
    assign res_push  = cmd_pop && (cmd.is_end || (cmd.len != '0));
    assign res_empty = (rcnt_reg == '0);
    assign res_pop   = pop && !res_empty;
    assign res_head  = rmem[rrd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (res_push)
            rmem[rwr_ptr_reg] <= res_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            rwr_ptr_reg <= '0;
            rrd_ptr_reg <= '0;
            rcnt_reg    <= '0;
        end
        else
        begin
            offset_reg <= offset_next;
            if (res_push)
                rwr_ptr_reg <= rwr_ptr_reg + RES_PTR_W'(1);
            if (res_pop)
                rrd_ptr_reg <= rrd_ptr_reg + RES_PTR_W'(1);
            if (res_push && !res_pop)
                rcnt_reg <= rcnt_reg + RES_CNT_W'(1);
            else if (res_pop && !res_push)
                rcnt_reg <= rcnt_reg - RES_CNT_W'(1);
        end
    end

`ifndef NO_ASSERTIONS
    a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && res_new.frame_end |-> res_new.run_length == '0 && !res_new.clipped)
        else $error("frame end result carries a run");

    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && !res_new.frame_end |-> res_new.run_length != '0 || res_new.clipped)
        else $error("empty run emitted without clip flag");

    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && !res_pop |-> rcnt_reg < RES_CNT_W'(RES_DEPTH))
        else $error("result queue overflow");

    a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && !cmd.is_end |=> offset_reg <= $past(area))
        else $error("offset ran past frame area");
`endif

endmodule

// ===== rtl/pck_rle_frame_decoder.sv =====
// Top level of the run-length sprite frame decoder: config registers and datapath.
// Throughput: one byte per cycle, sustained while pop keeps up with the results.
// A byte accepted by the classifier queues its command (if any); the executor then
//   moves its result (if any) into the result queue when that queue has room.
// Reset (rst_n low, async): expects a frame header, offset and frame number zero,
//   both queues empty, registers width 32, height 40, frame count 1.
// Config writes are taken every cycle (cfg_ready tied high); the area is registered.
module pck_rle_frame_decoder import prfd_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    // byte input, queue style
    input  logic                push,
    output logic                full,
    input  logic [W_COLOR-1:0]  data_byte,
    // result output, queue style
    output logic                empty,
    input  logic                pop,
    output logic [W_FRAME-1:0]  frame_index,
    output logic [W_OFFSET-1:0] start_offset,
    output logic [W_LEN-1:0]    run_length,
    output logic [W_COLOR-1:0]  color,
    output logic                frame_end,
    output logic                clipped,
    // register write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [W_CFGIDX-1:0] cfg_index,
    input  logic [W_COUNT-1:0]  cfg_data
);

    logic [W_DIM-1:0]   width_reg, height_reg;
    logic [W_COUNT-1:0] count_reg;
    logic [W_AREA-1:0]  area_reg;
    logic [W_DIM-1:0]   eff_w, eff_h;
    logic [W_COUNT-1:0] eff_count;
    logic [W_AREA-1:0]  area_prod;
    logic               cfg_wr;

    cmd_push_t          cmd_push;
    cmd_t               cmd_head;
    logic               cmd_full, cmd_empty, cmd_pop;
    res_t               res_head;
    logic               accept;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // out-of-range register values are clamped here, once
    assign eff_w     = clamp_dim(width_reg, W_DIM'(MAX_WIDTH));
    assign eff_h     = clamp_dim(height_reg, W_DIM'(MAX_HEIGHT));
    assign eff_count = clamp_count(count_reg);
    // at most 1024 * 1024, fits the area width
    assign area_prod = W_AREA'(eff_w) * W_AREA'(eff_h);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= W_DIM'(WIDTH_RESET);
            height_reg <= W_DIM'(HEIGHT_RESET);
            count_reg  <= W_COUNT'(COUNT_RESET);
            area_reg   <= W_AREA'(WIDTH_RESET * HEIGHT_RESET);
        end
        else
        begin
            // registered area keeps the multiplier out of the executor path
            area_reg <= area_prod;
            if (cfg_wr)
            begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg  <= cfg_data[W_DIM-1:0];
                    CFG_HEIGHT: height_reg <= cfg_data[W_DIM-1:0];
                    CFG_COUNT:  count_reg  <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    // a byte beat lands whenever the command queue has room
    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    prfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .eff_width (eff_w),
        .eff_count (eff_count),
        .cmd_push  (cmd_push)
    );

    prfd_cmd_queue u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_push (cmd_push),
        .pop      (cmd_pop),
        .full     (cmd_full),
        .empty    (cmd_empty),
        .head     (cmd_head)
    );

    prfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_head),
        .area      (area_reg),
        .pop       (pop),
        .cmd_pop   (cmd_pop),
        .res_empty (empty),
        .res_head  (res_head)
    );

    // result beat fields straight from the head of the result queue
    assign frame_index  = res_head.frame_index;
    assign start_offset = res_head.start_offset;
    assign run_length   = res_head.run_length;
    assign color        = res_head.color;
    assign frame_end    = res_head.frame_end;
    assign clipped      = res_head.clipped;

endmodule

// ===== tb/tb_pck_rle_frame_decoder.sv =====
// Self-checking testbench for the run-length sprite frame decoder.
module tb_pck_rle_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import prfd_pkg::*;

    // hold-off of the result side in the back-pressure phase, in cycles
    localparam int HOLD_CYCLES  = 60;
    // drain time after the last result: covers the four-entry command queue
    localparam int DRAIN_CYCLES = 4;
    // cycles with no beat on any channel before the run is declared hung
    localparam int STALL_LIMIT  = 2000;
    // stream bytes sent in the random part
    localparam int RANDOM_ITEMS = 700;
    // register index with no register behind it
    localparam logic [W_CFGIDX-1:0] CFG_SPARE = 2'd3;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [W_COLOR-1:0]  data_byte;
    logic                empty;
    logic                pop;
    logic [W_FRAME-1:0]  frame_index;
    logic [W_OFFSET-1:0] start_offset;
    logic [W_LEN-1:0]    run_length;
    logic [W_COLOR-1:0]  color;
    logic                frame_end;
    logic                clipped;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [W_CFGIDX-1:0] cfg_index;
    logic [W_COUNT-1:0]  cfg_data;

    pck_rle_frame_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .empty        (empty),
        .pop          (pop),
        .frame_index  (frame_index),
        .start_offset (start_offset),
        .run_length   (run_length),
        .color        (color),
        .frame_end    (frame_end),
        .clipped      (clipped),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Decoder mirror: register copies per register write, state once per byte beat
    // ------------------------------------------------------------------
    phase_t              dec_phase;
    int unsigned         raster_pos;
    int unsigned         frame_num;
    logic [W_DIM-1:0]    width_reg;
    logic [W_DIM-1:0]    height_reg;
    logic [W_COUNT-1:0]  count_reg;

    res_t expected_runs[$];      // pending pixel runs / frame-end marks, oldest first
    int   mismatches;
    int   stall_cycles;
    bit   tx_idle;               // sender inserts random gaps
    bit   rx_idle;               // receiver inserts random gaps
    bit   hold_rx;               // one-shot request for a long pop hold-off

    // directed plan: byte beats and register writes in order
    typedef struct {
        bit                  is_cfg;
        logic [W_CFGIDX-1:0] reg_idx;
        logic [W_COUNT-1:0]  value;
        bit                  typed;
        res_t                want;
    } plan_row_t;

    plan_row_t plan[$];

    // zero reads as one, anything past the maximum reads as the maximum
    function automatic int unsigned span_of(logic [W_DIM-1:0] v, int unsigned vmax);
        if (v == '0)
            return 1;
        if (v > vmax)
            return vmax;
        return v;
    endfunction

    function automatic bit decoding_active();
        int unsigned lim;
        lim = (count_reg > MAX_FRAMES) ? MAX_FRAMES : count_reg;
        return frame_num < lim;
    endfunction

    // one run against the area as it stands now; clip at the area end
    function automatic bit emit_run(int unsigned len, logic [W_COLOR-1:0] col,
                                    output res_t r);
        int unsigned area;
        int unsigned off;
        int unsigned avail;
        int unsigned n;
        bit          clip;
        r    = '0;
        area = span_of(width_reg, MAX_WIDTH) * span_of(height_reg, MAX_HEIGHT);
        // an offset left past a shrunk area counts as the area end
        off  = (raster_pos > area) ? area : raster_pos;
        if (len == 0)
        begin
            raster_pos = off;
            return 1'b0;
        end
        avail            = area - off;
        clip             = len > avail;
        n                = clip ? avail : len;
        r.frame_index    = W_FRAME'(frame_num);
        r.start_offset   = W_OFFSET'((off < area) ? off : area - 1);
        r.run_length     = W_LEN'(n);
        r.color          = col;
        r.clipped        = clip;
        raster_pos       = off + n;
        return 1'b1;
    endfunction

    function automatic bit decode_byte(logic [W_COLOR-1:0] b, output res_t r);
        r = '0;
        if (!decoding_active())
            return 1'b0;
        case (dec_phase)
            PH_HEADER:
            begin
                // blank rows come out as one transparent run
                raster_pos = 0;
                dec_phase  = PH_BODY;
                return emit_run(int'(b) * span_of(width_reg, MAX_WIDTH), '0, r);
            end
            PH_SKIP:
            begin
                dec_phase = PH_BODY;
                return emit_run(int'(b), '0, r);
            end
            default:
            begin
                dec_phase = PH_BODY;
                if (b == CODE_SKIP)
                begin
                    dec_phase = PH_SKIP;
                    return 1'b0;
                end
                if (b == CODE_END)
                begin
                    r.frame_index = W_FRAME'(frame_num);
                    r.frame_end   = 1'b1;
                    frame_num     = (frame_num + 1) & 32'h1FFF;
                    raster_pos    = 0;
                    dec_phase     = PH_HEADER;
                    return 1'b1;
                end
                return emit_run(1, b, r);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed plan builders
    // ------------------------------------------------------------------
    function automatic void add_byte(logic [W_COLOR-1:0] b);
        plan_row_t row;
        row        = '{default: '0};
        row.value  = W_COUNT'(b);
        plan.push_back(row);
    endfunction

    function automatic void add_run(logic [W_COLOR-1:0] b, int fi, int so, int rl,
                                    int col, bit fe, bit cl);
        plan_row_t row;
        row                   = '{default: '0};
        row.value             = W_COUNT'(b);
        row.typed             = 1'b1;
        row.want.frame_index  = W_FRAME'(fi);
        row.want.start_offset = W_OFFSET'(so);
        row.want.run_length   = W_LEN'(rl);
        row.want.color        = W_COLOR'(col);
        row.want.frame_end    = fe;
        row.want.clipped      = cl;
        plan.push_back(row);
    endfunction

    function automatic void add_cfg(logic [W_CFGIDX-1:0] idx, int v);
        plan_row_t row;
        row         = '{default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.value   = W_COUNT'(v);
        plan.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Random stream shaping: mostly well-formed frames, some noise
    // ------------------------------------------------------------------
    function automatic logic [W_COLOR-1:0] pick_byte();
        int r;
        r = $urandom_range(99, 0);
        case (dec_phase)
            PH_HEADER:
            begin
                if (r < 70)
                    return W_COLOR'($urandom_range(3, 0));
                if (r < 90)
                    return W_COLOR'($urandom_range(20, 0));
                return W_COLOR'($urandom_range(255, 0));
            end
            PH_SKIP:
            begin
                if (r < 50)
                    return W_COLOR'($urandom_range(12, 0));
                return W_COLOR'($urandom_range(255, 0));
            end
            default:
            begin
                if (r < 6)
                    return CODE_END;
                if (r < 16)
                    return CODE_SKIP;
                if (r < 20)
                    return W_COLOR'($urandom_range(255, 0));
                return W_COLOR'($urandom_range(253, 0));
            end
        endcase
    endfunction

    function automatic logic [W_COUNT-1:0] pick_span(int unsigned typical_max);
        case ($urandom_range(11, 0))
            0:       return '0;
            1:       return W_COUNT'(1);
            2:       return W_COUNT'(1024);
            3:       return W_COUNT'(2047);
            4:       return W_COUNT'($urandom_range(2047, 0));
            default: return W_COUNT'($urandom_range(typical_max, 2));
        endcase
    endfunction

    function automatic logic [W_COUNT-1:0] pick_count(int phase_no);
        if (phase_no == 3)
            return '0;                          // decodes nothing
        if (phase_no == 2)
            return W_COUNT'(8191);              // keep the back-pressure phase busy
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return W_COUNT'(8191);
            2:       return W_COUNT'(MAX_FRAMES);
            3:       return W_COUNT'($urandom_range(8191, 0));
            4, 5:    return W_COUNT'(frame_num + $urandom_range(3, 1));
            default: return W_COUNT'(4095);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers. Every task is entered at a rising-edge step and
    // returns at the step of its beat, having issued no drive in that step.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [W_COLOR-1:0] b, input bit typed,
                             input res_t want);
        int   gap;
        res_t got;
        bit   made;
        gap = tx_idle ? $urandom_range(7, 0) : 0;
        cfg_valid <= 1'b0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (full);
        // beat taken at this edge: advance the mirror
        made = decode_byte(b, got);
        if (typed)
            expected_runs.push_back(want);
        else if (made)
            expected_runs.push_back(got);
    endtask

    task automatic write_reg(input logic [W_CFGIDX-1:0] idx, input logic [W_COUNT-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_WIDTH:  width_reg  = value[W_DIM-1:0];
            CFG_HEIGHT: height_reg = value[W_DIM-1:0];
            CFG_COUNT:  count_reg  = value;
            default:    ;
        endcase
    endtask

    // stop offering, let every pending result out, then cover bytes still
    // in flight that cause no result
    task automatic wait_idle();
        push      <= 1'b0;
        cfg_valid <= 1'b0;
        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    task automatic check_run();
        res_t want;
        if (expected_runs.size() == 0)
        begin
            mismatches++;
            $display({"%0t: result with nothing pending: frame %0d offset %0d len %0d",
                      " color %0d end %0b clip %0b"},
                     $time, frame_index, start_offset, run_length, color, frame_end,
                     clipped);
            return;
        end
        want = expected_runs.pop_front();
        compare_field("frame_index",  want.frame_index,  frame_index);
        compare_field("start_offset", want.start_offset, start_offset);
        compare_field("run_length",   want.run_length,   run_length);
        compare_field("color",        want.color,        color);
        compare_field("frame_end",    want.frame_end,    frame_end);
        compare_field("clipped",      want.clipped,      clipped);
    endtask

    // ------------------------------------------------------------------
    // Result side: random pop gaps, one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int gap;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = rx_idle ? $urandom_range(7, 0) : 0;
            if (hold_rx)
            begin
                // long stall so the byte side backs up and raises full
                gap     = HOLD_CYCLES;
                hold_rx = 1'b0;
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            check_run();
        end
    end

    // Hang detection: any beat on any channel restarts the count
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("pck_rle_frame_decoder verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [W_COLOR-1:0] stream_byte;
        int                 phase_num;
        int                 batch;
        int                 items_done;
        bit                 prev_byte;
        bit                 pressure;

        rst_n        <= 1'b0;
        push         <= 1'b0;
        data_byte    <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        mismatches   = 0;
        stall_cycles = 0;
        hold_rx      = 1'b0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;

        // mirror starts from the reset state
        dec_phase  = PH_HEADER;
        raster_pos = 0;
        frame_num  = 0;
        width_reg  = W_DIM'(WIDTH_RESET);
        height_reg = W_DIM'(HEIGHT_RESET);
        count_reg  = W_COUNT'(COUNT_RESET);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Reset registers: 32 x 40 area, one frame.
        add_byte(8'd0);                              // header with no blank rows: no run
        add_run(8'd0,   0, 0, 1, 0, 0, 0);           // lowest colour
        add_run(8'd253, 0, 1, 1, 253, 0, 0);         // highest colour
        add_byte(CODE_SKIP);
        add_byte(8'd0);                              // empty skip: no run
        add_byte(CODE_SKIP);
        add_run(8'd255, 0, 2, 255, 0, 0, 0);         // longest skip
        add_run(CODE_END, 0, 0, 0, 0, 1, 0);         // frame end mark
        add_byte(8'h5A);                             // past the last frame: ignored
        add_cfg(CFG_COUNT, 8191);                    // above the frame maximum
        add_cfg(CFG_WIDTH, 0);                       // zero width acts as one
        add_cfg(CFG_HEIGHT, 2047);                   // acts as the height maximum
        add_run(8'd255, 1, 0, 255, 0, 0, 0);         // tallest header
        add_byte(CODE_SKIP);
        add_run(8'd255, 1, 255, 255, 0, 0, 0);
        add_run(CODE_END, 1, 0, 0, 0, 1, 0);
        add_cfg(CFG_WIDTH, 2047);                    // acts as the width maximum
        add_cfg(CFG_HEIGHT, 0);                      // zero height acts as one
        add_run(8'd1, 2, 0, 1024, 0, 0, 0);          // blank row fills the area
        add_run(8'd7, 2, 1023, 0, 7, 0, 1);          // fully clipped pixel
        add_run(CODE_END, 2, 0, 0, 0, 1, 0);
        add_cfg(CFG_WIDTH, 1);
        add_cfg(CFG_HEIGHT, 1);
        add_run(8'd2, 3, 0, 1, 0, 0, 1);             // header cut at the area end
        add_byte(CODE_SKIP);
        add_byte(8'd0);
        add_run(CODE_END, 3, 0, 0, 0, 1, 0);
        add_cfg(CFG_SPARE, 13'h1555);                // unused index, no effect

        prev_byte = 1'b1;
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                // registers change only with the pipe empty
                if (prev_byte)
                    wait_idle();
                write_reg(plan[i].reg_idx, plan[i].value);
                prev_byte = 1'b0;
            end
            else
            begin
                send_byte(plan[i].value[W_COLOR-1:0], plan[i].typed, plan[i].want);
                prev_byte = 1'b1;
            end
        end

        // Random part: phases of register settings, each followed by a burst
        // of stream bytes. Phase 2 is the back-pressure phase, phase 3 has a
        // frame count of zero.
        phase_num  = 0;
        items_done = 0;
        while (items_done < RANDOM_ITEMS)
        begin
            wait_idle();
            if ($urandom_range(3, 0) != 0)
                write_reg(CFG_WIDTH, pick_span(24));
            if ($urandom_range(3, 0) != 0)
                write_reg(CFG_HEIGHT, pick_span(12));
            write_reg(CFG_COUNT, pick_count(phase_num));
            if ($urandom_range(15, 0) == 0)
                write_reg(CFG_SPARE, W_COUNT'($urandom_range(8191, 0)));

            pressure = (phase_num == 2);
            tx_idle  = pressure ? 1'b0 : ($urandom_range(2, 0) != 0);
            rx_idle  = $urandom_range(2, 0) != 0;
            if (pressure)
                hold_rx = 1'b1;
            batch = pressure ? 120 : $urandom_range(100, 30);

            repeat (batch)
            begin
                stream_byte = pick_byte();
                items_done++;
                send_byte(stream_byte, 1'b0, '0);
            end
            phase_num++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("pck_rle_frame_decoder verification clean");
        else
            $display("pck_rle_frame_decoder verification failed");
        $finish;
    end

endmodule

// ===== pck_rle_frame_decoder.f =====
rtl/prfd_pkg.sv
rtl/prfd_front.sv
rtl/prfd_cmd_queue.sv
rtl/prfd_back.sv
rtl/pck_rle_frame_decoder.sv
tb/tb_pck_rle_frame_decoder.sv
